// ===== rtl/ptdt_pkg.sv =====
// shared constants, types and codes of the deadline timer table
package ptdt_pkg;

    localparam int THREAD_TYPES      = 4;
    localparam int PROCS_PER_TYPE    = 16;
    localparam int TIMERS_PER_THREAD = 4;

    localparam int KIND_W     = 2;
    localparam int TTYPE_W    = 2;
    localparam int PROC_W     = 4;
    localparam int TIDX_W     = 2;
    localparam int DL_W       = 32;
    localparam int REPORT_W   = 3;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 8;

    localparam int ROWS       = THREAD_TYPES * PROCS_PER_TYPE;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_BITS   = TIMERS_PER_THREAD * DL_W;
    localparam int TSEL_W     = (TIMERS_PER_THREAD > 1) ? $clog2(TIMERS_PER_THREAD) : 1;

    localparam logic [DL_W-1:0] HALF_RANGE = DL_W'(32'hffffffff / 2);

    typedef logic [TIMERS_PER_THREAD-1:0][DL_W-1:0] row_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_CHECK = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic              group_ok;
        logic              timer_ok;
        logic [TIDX_W-1:0] timer_index;
        logic [DL_W-1:0]   duration;
    } cmd_t;

endpackage

// ===== rtl/ptdt_ram.sv =====
// generic single-port-write ram with registered read
module ptdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ptdt_update.sv =====
// read-modify-write of one thread's deadline row
module ptdt_update import ptdt_pkg::*; (
    input  cmd_t                cmd,
    input  row_t                row_in,
    input  logic [DL_W-1:0]     now,
    output row_t                row_out,
    output logic                wr_en,
    output logic [REPORT_W-1:0] report
);

    logic [TIMERS_PER_THREAD-1:0] expired;
    logic [TSEL_W-1:0]            sel;

    always_comb
    begin
        for (int i = 0; i < TIMERS_PER_THREAD; i++)
        begin
            expired[i] = (row_in[i] != '0) && ((row_in[i] - now) > HALF_RANGE);
        end
    end

    always_comb
    begin
        sel     = cmd.timer_index[TSEL_W-1:0];
        row_out = row_in;
        wr_en   = 1'b0;
        report  = '0;
        unique case (cmd.kind)
            KIND_TICK:
            begin
                wr_en = 1'b0;
            end
            KIND_SET:
            begin
                if (cmd.group_ok && cmd.timer_ok)
                begin
                    row_out[sel] = cmd.duration + now;
                    wr_en        = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                if (cmd.group_ok && cmd.timer_ok)
                begin
                    row_out[sel] = '0;
                    wr_en        = 1'b1;
                end
            end
            KIND_CHECK:
            begin
                if (cmd.group_ok)
                begin
                    for (int i = TIMERS_PER_THREAD - 1; i >= 0; i--)
                    begin
                        if (expired[i])
                        begin
                            row_out     = row_in;
                            row_out[i]  = '0;
                            wr_en       = 1'b1;
                            report      = REPORT_W'(i + 1);
                        end
                    end
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/per_thread_deadline_timer_table.sv =====
// top level of the per-thread deadline timer table
//
// input channel s_*: one transfer per command. s_tuser carries the kind
// (tick, set, clear, check); s_tdata carries thread type, process number,
// timer index and duration. output channel m_*: exactly one transfer per
// command, m_tdata[2:0] is the expired timer index plus one for a check
// and zero otherwise.
// the accept cycle reads the thread's row of deadlines from the row ram;
// the exec state that follows modifies it and writes it back once the
// output register is free. s_tready is low in exec, so no new command is
// taken until the last one has finished.
// m_tvalid is registered and is set at the edge that ends the exec state,
// together with any write-back of the row.
// reset clears the millisecond counter and a per-row valid flag; a row whose
// flag is clear reads as all zero, so every timer starts inactive with no
// clearing pass.
// when the receiver stalls, the finished result waits in the output
// register; one more command is accepted and then holds in its modify
// cycle until the output register frees up.
module per_thread_deadline_timer_table import ptdt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // thread_type, process_num, timer_index, duration
    input  logic [S_DATA_W-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // expired_timer, zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    state_t                 state_reg, state_next;
    logic [DL_W-1:0]        now_reg, now_next;
    logic [ROWS-1:0]        row_valid_reg, row_valid_next;
    logic                   rd_valid_reg, rd_valid_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [REPORT_W-1:0]    report_reg, report_next;

    logic [TTYPE_W-1:0]     in_ttype;
    logic [PROC_W-1:0]      in_proc;
    logic [TIDX_W-1:0]      in_tidx;
    logic [DL_W-1:0]        in_dur;
    logic [ROW_W-1:0]       in_row;
    logic                   accept;
    logic                   finish;
    logic [ROW_BITS-1:0]    ram_q;
    row_t                   row_cur;
    row_t                   row_new;
    logic                   upd_wr;
    logic [REPORT_W-1:0]    upd_report;

    assign in_ttype = s_tdata[TTYPE_W-1:0];
    assign in_proc  = s_tdata[TTYPE_W +: PROC_W];
    assign in_tidx  = s_tdata[TTYPE_W + PROC_W +: TIDX_W];
    assign in_dur   = s_tdata[TTYPE_W + PROC_W + TIDX_W +: DL_W];
    assign in_row   = ROW_W'(ROW_W'(in_ttype) * ROW_W'(PROCS_PER_TYPE)) + ROW_W'(in_proc);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign row_cur  = rd_valid_reg ? row_t'(ram_q) : row_t'('0);

    ptdt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (finish && upd_wr),
        .waddr (row_reg),
        .wdata (ROW_BITS'(row_new)),
        .re    (accept),
        .raddr (in_row),
        .rdata (ram_q)
    );

    ptdt_update u_update (
        .cmd     (cmd_reg),
        .row_in  (row_cur),
        .now     (now_reg),
        .row_out (row_new),
        .wr_en   (upd_wr),
        .report  (upd_report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            row_valid_reg <= row_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= rd_valid_next;
        cmd_reg      <= cmd_next;
        row_reg      <= row_next;
        report_reg   <= report_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        report_next    = report_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.kind        = kind_t'(s_tuser);
                    cmd_next.group_ok    = (32'(in_ttype) < 32'(THREAD_TYPES))
                                        && (32'(in_proc) < 32'(PROCS_PER_TYPE));
                    cmd_next.timer_ok    = 32'(in_tidx) < 32'(TIMERS_PER_THREAD);
                    cmd_next.timer_index = in_tidx;
                    cmd_next.duration    = in_dur;
                    row_next             = in_row;
                    rd_valid_next        = row_valid_reg[in_row];
                    state_next           = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    if (cmd_reg.kind == KIND_TICK)
                    begin
                        now_next = now_reg + DL_W'(1);
                    end
                    if (upd_wr)
                    begin
                        row_valid_next[row_reg] = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    report_next   = upd_report;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(report_reg);

endmodule
